// ===== src/vector4_orthonormalize_top_defines.svh =====
// Assertion macros used by the checker file of the orthonormalizer.
`ifndef VECTOR4_ORTHONORMALIZE_TOP_DEFINES_SVH
`define VECTOR4_ORTHONORMALIZE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/vo_pkg.sv =====
package vo_pkg;

   localparam int COMPONENT_BITS = 16;
   localparam int LANES          = 4;
   localparam int Q_W            = 16;
   localparam int FRAC_BITS      = Q_W - 1;
   localparam int NN_W           = 2 * COMPONENT_BITS + 1;
   localparam int TN_W           = 2 * COMPONENT_BITS + 2;
   localparam int RES_W          = 3 * COMPONENT_BITS + 2;
   localparam int LEN_W          = $clog2(RES_W + 1);
   localparam int A_W            = 30;
   localparam int SQ_W           = 2 * A_W;
   localparam int SUM_W          = SQ_W + 2;
   localparam int ROOT_W         = SUM_W / 2;
   localparam int NUM_W          = A_W + Q_W;
   localparam int PRE_STAGES     = 5;
   localparam int UNIT_LAT       = 5 + ROOT_W + Q_W + 1;
   localparam int PIPE_DEPTH     = PRE_STAGES + UNIT_LAT;

   localparam logic [Q_W-1:0] Q_MAX = Q_W'((1 << FRAC_BITS) - 1);

   typedef logic signed [RES_W-1:0] wide_type;
   typedef wide_type vec4_type [LANES];

   typedef struct packed {
      logic                         zero;
      logic [LANES-1:0][Q_W-1:0]    q;
   } unit_out_type;

   typedef struct packed {
      logic signed [COMPONENT_BITS-1:0] normal_x;
      logic signed [COMPONENT_BITS-1:0] normal_y;
      logic signed [COMPONENT_BITS-1:0] normal_z;
      logic signed [COMPONENT_BITS-1:0] normal_w;
      logic signed [COMPONENT_BITS-1:0] tangent_x;
      logic signed [COMPONENT_BITS-1:0] tangent_y;
      logic signed [COMPONENT_BITS-1:0] tangent_z;
      logic signed [COMPONENT_BITS-1:0] tangent_w;
   } req_type;

   typedef struct packed {
      logic signed [Q_W-1:0] unit_normal_x;
      logic signed [Q_W-1:0] unit_normal_y;
      logic signed [Q_W-1:0] unit_normal_z;
      logic signed [Q_W-1:0] unit_normal_w;
      logic signed [Q_W-1:0] unit_tangent_x;
      logic signed [Q_W-1:0] unit_tangent_y;
      logic signed [Q_W-1:0] unit_tangent_z;
      logic signed [Q_W-1:0] unit_tangent_w;
      logic                  normal_is_zero;
      logic                  tangent_degenerate;
   } rsp_type;

endpackage

// ===== src/vo_isqrt.sv =====
module vo_isqrt (
   input  logic                       clock,
   input  logic                       en,
   input  logic [vo_pkg::SUM_W-1:0]   sum_i,
   output logic [vo_pkg::ROOT_W-1:0]  root_o
);
   import vo_pkg::*;

   logic [SUM_W-1:0]  rem_ff  [ROOT_W];
   logic [SUM_W-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];

   // One result bit per stage, most significant first.
   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      localparam int K = ROOT_W - 1 - i;
      logic [SUM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SUM_W:0]    trial;

      if (i == 0) begin : g_first
         assign rem_prev  = sum_i;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
      end

      always_comb begin
         trial = ((SUM_W + 1)'(root_prev) << (K + 1)) | ((SUM_W + 1)'(1) << (2 * K));
         if ({1'b0, rem_prev} >= trial) begin
            rem_in[i]  = rem_prev - trial[SUM_W-1:0];
            root_in[i] = root_prev | (ROOT_W'(1) << K);
         end else begin
            rem_in[i]  = rem_prev;
            root_in[i] = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
         end
      end
   end

   assign root_o = root_ff[ROOT_W-1];

endmodule

// ===== src/vo_div_lane.sv =====
module vo_div_lane (
   input  logic                       clock,
   input  logic                       en,
   input  logic [vo_pkg::A_W-1:0]     a_i,
   input  logic [vo_pkg::ROOT_W-1:0]  d_i,
   output logic [vo_pkg::Q_W-1:0]     q_o
);
   import vo_pkg::*;

   logic [NUM_W-1:0]  rem_ff [Q_W];
   logic [NUM_W-1:0]  rem_in [Q_W];
   logic [ROOT_W-1:0] d_ff   [Q_W];
   logic [Q_W-1:0]    q_ff   [Q_W];
   logic [Q_W-1:0]    q_in   [Q_W];

   // Rounded quotient: the half divisor is added to the scaled dividend up front.
   for (genvar i = 0; i < Q_W; i++) begin : g_stage
      localparam int B = Q_W - 1 - i;
      logic [NUM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] d_prev;
      logic [Q_W-1:0]    q_prev;
      logic [NUM_W-1:0]  dd;

      if (i == 0) begin : g_first
         assign rem_prev = (NUM_W'(a_i) << FRAC_BITS) + NUM_W'(d_i >> 1);
         assign d_prev   = d_i;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign d_prev   = d_ff[i-1];
         assign q_prev   = q_ff[i-1];
      end

      always_comb begin
         dd = NUM_W'(d_prev) << B;
         if (rem_prev >= dd) begin
            rem_in[i] = rem_prev - dd;
            q_in[i]   = q_prev | (Q_W'(1) << B);
         end else begin
            rem_in[i] = rem_prev;
            q_in[i]   = q_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in[i];
            d_ff[i]   <= d_prev;
            q_ff[i]   <= q_in[i];
         end
      end
   end

   assign q_o = q_ff[Q_W-1];

endmodule

// ===== src/vo_unitize.sv =====
module vo_unitize (
   input  logic                 clock,
   input  logic                 en,
   input  vo_pkg::vec4_type     vec_i,
   output vo_pkg::unit_out_type res_o
);
   import vo_pkg::*;

   localparam int SB_DEPTH = ROOT_W + Q_W;

   function automatic logic [LEN_W-1:0] bit_len(input logic [RES_W-1:0] v);
      logic [LEN_W-1:0] n;
      n = '0;
      for (int b = 0; b < RES_W; b++) begin
         if (v[b]) n = LEN_W'(b + 1);
      end
      return n;
   endfunction

   logic [LANES-1:0][RES_W-1:0] mag_a_in, mag_a_ff, mag_b_ff;
   logic [LANES-1:0]            neg_a_in, neg_a_ff, neg_b_ff, neg_c_ff, neg_d_ff, neg_e_ff;
   logic [RES_W-1:0]            or_a_in, or_a_ff;
   logic [LEN_W-1:0]            len_b_ff;
   logic                        zero_b_ff, zero_c_ff, zero_d_ff, zero_e_ff;
   logic [LANES-1:0][A_W-1:0]   a_c_in, a_c_ff, a_d_ff, a_e_ff;
   logic [LANES-1:0][SQ_W-1:0]  sq_d_in, sq_d_ff;
   logic [SUM_W-1:0]            sum_e_in, sum_e_ff;
   logic [LANES-1:0][A_W-1:0]   a_dl_ff [ROOT_W];
   logic [LANES:0]              flag_dl_ff [SB_DEPTH];
   logic [ROOT_W-1:0]           root;
   logic [LANES-1:0][Q_W-1:0]   quo;
   unit_out_type                res_in, res_ff;

   always_comb begin
      or_a_in = '0;
      for (int i = 0; i < LANES; i++) begin
         neg_a_in[i] = vec_i[i][RES_W-1];
         mag_a_in[i] = neg_a_in[i] ? RES_W'(-vec_i[i]) : RES_W'(vec_i[i]);
         or_a_in     = or_a_in | mag_a_in[i];
      end
   end

   // The largest component is moved so that its top bit lands just below A_W.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         a_c_in[i]  = A_W'({mag_b_ff[i], {A_W{1'b0}}} >> len_b_ff);
         sq_d_in[i] = SQ_W'(a_c_ff[i]) * SQ_W'(a_c_ff[i]);
      end
      sum_e_in = SUM_W'(sq_d_ff[0]) + SUM_W'(sq_d_ff[1]) + SUM_W'(sq_d_ff[2])
               + SUM_W'(sq_d_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_a_ff  <= mag_a_in;
         neg_a_ff  <= neg_a_in;
         or_a_ff   <= or_a_in;
         len_b_ff  <= bit_len(or_a_ff);
         mag_b_ff  <= mag_a_ff;
         neg_b_ff  <= neg_a_ff;
         zero_b_ff <= (or_a_ff == '0);
         a_c_ff    <= a_c_in;
         neg_c_ff  <= neg_b_ff;
         zero_c_ff <= zero_b_ff;
         sq_d_ff   <= sq_d_in;
         a_d_ff    <= a_c_ff;
         neg_d_ff  <= neg_c_ff;
         zero_d_ff <= zero_c_ff;
         sum_e_ff  <= sum_e_in;
         a_e_ff    <= a_d_ff;
         neg_e_ff  <= neg_d_ff;
         zero_e_ff <= zero_d_ff;
         a_dl_ff[0]    <= a_e_ff;
         flag_dl_ff[0] <= {zero_e_ff, neg_e_ff};
         for (int k = 1; k < ROOT_W; k++) a_dl_ff[k] <= a_dl_ff[k-1];
         for (int k = 1; k < SB_DEPTH; k++) flag_dl_ff[k] <= flag_dl_ff[k-1];
         res_ff <= res_in;
      end
   end

   vo_isqrt u_isqrt (
      .clock  (clock),
      .en     (en),
      .sum_i  (sum_e_ff),
      .root_o (root)
   );

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      vo_div_lane u_div (
         .clock (clock),
         .en    (en),
         .a_i   (a_dl_ff[ROOT_W-1][i]),
         .d_i   (root),
         .q_o   (quo[i])
      );
   end

   always_comb begin
      logic [Q_W-1:0] qs;
      res_in.zero = flag_dl_ff[SB_DEPTH-1][LANES];
      for (int i = 0; i < LANES; i++) begin
         qs = (quo[i] > Q_MAX) ? Q_MAX : quo[i];
         if (res_in.zero) res_in.q[i] = '0;
         else if (flag_dl_ff[SB_DEPTH-1][i]) res_in.q[i] = -qs;
         else res_in.q[i] = qs;
      end
   end

   assign res_o = res_ff;

endmodule

// ===== src/vector4_orthonormalize_top.sv =====
// Throughput: one request per cycle unless the output buffer is full; the depth is set
// by the 31-stage square root and the 16-stage per-lane divider that follow the residual
// and scaling stages.
// A two-entry output buffer keeps the pipeline moving while one result waits.
// Reset (synchronous, active high) clears the valid bits and the buffer count;
// data registers are not reset.
module vector4_orthonormalize_top (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  vo_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output vo_pkg::rsp_type rsp_data
);
   import vo_pkg::*;

   // The whole pipeline advances together; it holds only when the output
   // buffer is full, so a request is taken even while one result is waiting.
   logic                          en;
   logic                          push;
   logic                          pop;
   logic [PIPE_DEPTH-1:0]         vld_ff;

   logic signed [COMPONENT_BITS-1:0] n1_ff [LANES];
   logic signed [COMPONENT_BITS-1:0] t1_ff [LANES];
   logic signed [COMPONENT_BITS-1:0] n2_ff [LANES];
   logic signed [COMPONENT_BITS-1:0] t2_ff [LANES];
   logic signed [COMPONENT_BITS-1:0] n3_ff [LANES];
   logic signed [COMPONENT_BITS-1:0] t3_ff [LANES];
   logic signed [COMPONENT_BITS-1:0] n4_ff [LANES];
   logic signed [COMPONENT_BITS-1:0] n5_ff [LANES];
   logic signed [2*COMPONENT_BITS-1:0] nsq2_ff [LANES];
   logic signed [2*COMPONENT_BITS-1:0] tnp2_ff [LANES];
   logic [NN_W-1:0]               nn_in, nn3_ff;
   logic signed [TN_W-1:0]        tn_in, tn3_ff;
   logic signed [RES_W-1:0]       tp4_ff [LANES];
   logic signed [RES_W-1:0]       np4_ff [LANES];
   logic signed [RES_W-1:0]       r5_ff  [LANES];

   vec4_type                      nvec;
   vec4_type                      rvec;
   unit_out_type                  unit_n;
   unit_out_type                  unit_r;

   rsp_type                       rsp_in;
   rsp_type                       buf0_in, buf0_ff;
   rsp_type                       buf1_in, buf1_ff;
   logic [1:0]                    cnt_in, cnt_ff;

   assign en        = (cnt_ff != 2'd2);
   assign req_ready = en;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = buf0_ff;
   assign push      = en && vld_ff[PIPE_DEPTH-1];
   assign pop       = rsp_valid && rsp_ready;

   // Dot products n.n and t.n are summed exactly from the per-lane products.
   assign nn_in = NN_W'(nsq2_ff[0]) + NN_W'(nsq2_ff[1]) + NN_W'(nsq2_ff[2])
                + NN_W'(nsq2_ff[3]);
   assign tn_in = TN_W'(tnp2_ff[0]) + TN_W'(tnp2_ff[1]) + TN_W'(tnp2_ff[2])
                + TN_W'(tnp2_ff[3]);

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff[0] <= req_data.normal_x;
         n1_ff[1] <= req_data.normal_y;
         n1_ff[2] <= req_data.normal_z;
         n1_ff[3] <= req_data.normal_w;
         t1_ff[0] <= req_data.tangent_x;
         t1_ff[1] <= req_data.tangent_y;
         t1_ff[2] <= req_data.tangent_z;
         t1_ff[3] <= req_data.tangent_w;
         for (int i = 0; i < LANES; i++) begin
            nsq2_ff[i] <= n1_ff[i] * n1_ff[i];
            tnp2_ff[i] <= t1_ff[i] * n1_ff[i];
            n2_ff[i]   <= n1_ff[i];
            t2_ff[i]   <= t1_ff[i];
            n3_ff[i]   <= n2_ff[i];
            t3_ff[i]   <= t2_ff[i];
            // The residual t*(n.n) - n*(t.n) is formed without any rounding.
            tp4_ff[i]  <= t3_ff[i] * $signed({1'b0, nn3_ff});
            np4_ff[i]  <= n3_ff[i] * tn3_ff;
            n4_ff[i]   <= n3_ff[i];
            r5_ff[i]   <= tp4_ff[i] - np4_ff[i];
            n5_ff[i]   <= n4_ff[i];
         end
         nn3_ff <= nn_in;
         tn3_ff <= tn_in;
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         nvec[i] = RES_W'(n5_ff[i]);
         rvec[i] = r5_ff[i];
      end
   end

   // Both vectors run through identical normalizers so their results line up.
   vo_unitize u_unit_n (
      .clock (clock),
      .en    (en),
      .vec_i (nvec),
      .res_o (unit_n)
   );

   vo_unitize u_unit_r (
      .clock (clock),
      .en    (en),
      .vec_i (rvec),
      .res_o (unit_r)
   );

   // A zero normal zeroes everything, the tangent flag included.
   always_comb begin
      rsp_in.unit_normal_x      = unit_n.q[0];
      rsp_in.unit_normal_y      = unit_n.q[1];
      rsp_in.unit_normal_z      = unit_n.q[2];
      rsp_in.unit_normal_w      = unit_n.q[3];
      rsp_in.unit_tangent_x     = unit_n.zero ? '0 : unit_r.q[0];
      rsp_in.unit_tangent_y     = unit_n.zero ? '0 : unit_r.q[1];
      rsp_in.unit_tangent_z     = unit_n.zero ? '0 : unit_r.q[2];
      rsp_in.unit_tangent_w     = unit_n.zero ? '0 : unit_r.q[3];
      rsp_in.normal_is_zero     = unit_n.zero;
      rsp_in.tangent_degenerate = !unit_n.zero && unit_r.zero;
   end

   // Two-entry output buffer; the head entry drives the result port.
   always_comb begin
      cnt_in  = cnt_ff;
      buf0_in = buf0_ff;
      buf1_in = buf1_ff;
      unique case (cnt_ff)
         2'd0: begin
            if (push) begin
               buf0_in = rsp_in;
               cnt_in  = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               buf0_in = rsp_in;
            end else if (push) begin
               buf1_in = rsp_in;
               cnt_in  = 2'd2;
            end else if (pop) begin
               cnt_in  = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               buf0_in = buf1_ff;
               cnt_in  = 2'd1;
            end
         end
         default: begin
            cnt_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      buf0_ff <= buf0_in;
      buf1_ff <= buf1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         cnt_ff <= 2'd0;
      end else begin
         if (en) vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== src/vo_check.sv =====
`include "vector4_orthonormalize_top_defines.svh"

module vo_check (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input vo_pkg::rsp_type rsp_data
);

   `VO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")
   `VO_ASSERT_NOW(a_zero_normal, clock, reset, rsp_valid && rsp_data.normal_is_zero, rsp_data.unit_normal_x == 0 && rsp_data.unit_normal_y == 0 && rsp_data.unit_normal_z == 0 && rsp_data.unit_normal_w == 0 && rsp_data.unit_tangent_x == 0 && rsp_data.unit_tangent_y == 0 && rsp_data.unit_tangent_z == 0 && rsp_data.unit_tangent_w == 0 && !rsp_data.tangent_degenerate, "zero normal gave nonzero fields")
   `VO_ASSERT_NOW(a_degenerate, clock, reset, rsp_valid && rsp_data.tangent_degenerate, rsp_data.unit_tangent_x == 0 && rsp_data.unit_tangent_y == 0 && rsp_data.unit_tangent_z == 0 && rsp_data.unit_tangent_w == 0 && !rsp_data.normal_is_zero, "degenerate tangent not zeroed")
   `VO_ASSERT_NOW(a_unit_nonzero, clock, reset, rsp_valid && !rsp_data.normal_is_zero, rsp_data.unit_normal_x != 0 || rsp_data.unit_normal_y != 0 || rsp_data.unit_normal_z != 0 || rsp_data.unit_normal_w != 0, "unit normal is all zero")
   `VO_ASSERT_NOW(a_no_full_neg, clock, reset, rsp_valid, rsp_data.unit_normal_x != 16'sh8000 && rsp_data.unit_tangent_x != 16'sh8000, "output below saturation limit")

endmodule

bind vector4_orthonormalize_top vo_check u_vo_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== bench/vector4_orthonormalize_top_tb.sv =====
`timescale 1ns / 100ps

import vo_pkg::*;

// Holds the results still owed by the orthonormalizer and checks each one
// as it arrives.
class frame_scoreboard;
   rsp_type owed_q[$];
   int      errors;

   function new();
      errors = 0;
   endfunction

   static function logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe = probe >> 2;
      while (probe != 0) begin
         if (x >= root + probe) begin
            x    = x - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Scales a wide vector so its largest magnitude has 30 bits, then
   // divides by the truncated length. Returns 0 for an all-zero vector.
   static function bit to_unit(input logic signed [127:0] v[4],
                               output logic [15:0] q[4]);
      logic [127:0] mag[4];
      bit           neg[4];
      logic [63:0]  a[4];
      logic [63:0]  sum_sq, root, quot;
      int           len, blen;
      len    = 0;
      sum_sq = 0;
      for (int i = 0; i < 4; i++) begin
         neg[i] = v[i][127];
         mag[i] = neg[i] ? -v[i] : v[i];
         blen   = 0;
         for (int b = 0; b < 128; b++)
            if (mag[i][b]) blen = b + 1;
         if (blen > len) len = blen;
      end
      if (len == 0) begin
         for (int i = 0; i < 4; i++) q[i] = '0;
         return 0;
      end
      for (int i = 0; i < 4; i++) begin
         if (len > 30) a[i] = 64'(mag[i] >> (len - 30));
         else          a[i] = 64'(mag[i] << (30 - len));
         sum_sq += a[i] * a[i];
      end
      root = floor_sqrt(sum_sq);
      for (int i = 0; i < 4; i++) begin
         quot = (a[i] * 64'd32768 + root / 2) / root;
         if (quot > 64'd32767) quot = 64'd32767;
         q[i] = neg[i] ? 16'(17'h10000 - quot) : quot[15:0];
      end
      return 1;
   endfunction

   static function rsp_type orthonormalize(req_type r);
      logic signed [127:0] n[4], t[4], resid[4];
      logic signed [127:0] nn, tn;
      logic [15:0]         un[4], ut[4];
      rsp_type             o;
      n[0] = r.normal_x;  n[1] = r.normal_y;  n[2] = r.normal_z;  n[3] = r.normal_w;
      t[0] = r.tangent_x; t[1] = r.tangent_y; t[2] = r.tangent_z; t[3] = r.tangent_w;
      nn = 0;
      tn = 0;
      o  = '0;
      for (int i = 0; i < 4; i++) begin
         nn += n[i] * n[i];
         tn += t[i] * n[i];
      end
      if (!to_unit(n, un)) begin
         o.normal_is_zero = 1'b1;
         return o;
      end
      for (int i = 0; i < 4; i++) resid[i] = t[i] * nn - n[i] * tn;
      o.tangent_degenerate = !to_unit(resid, ut);
      o.unit_normal_x  = un[0]; o.unit_normal_y  = un[1];
      o.unit_normal_z  = un[2]; o.unit_normal_w  = un[3];
      o.unit_tangent_x = ut[0]; o.unit_tangent_y = ut[1];
      o.unit_tangent_z = ut[2]; o.unit_tangent_w = ut[3];
      return o;
   endfunction

   function void note_request(req_type r);
      owed_q.push_back(orthonormalize(r));
   endfunction

   function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: mismatch in %s, expected %0d, actual %0d",
                  $time, name, $signed(want), $signed(got));
         errors++;
      end
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (owed_q.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %h", $time, got);
         errors++;
         return;
      end
      want = owed_q.pop_front();
      compare_field("unit_normal_x",  want.unit_normal_x,  got.unit_normal_x);
      compare_field("unit_normal_y",  want.unit_normal_y,  got.unit_normal_y);
      compare_field("unit_normal_z",  want.unit_normal_z,  got.unit_normal_z);
      compare_field("unit_normal_w",  want.unit_normal_w,  got.unit_normal_w);
      compare_field("unit_tangent_x", want.unit_tangent_x, got.unit_tangent_x);
      compare_field("unit_tangent_y", want.unit_tangent_y, got.unit_tangent_y);
      compare_field("unit_tangent_z", want.unit_tangent_z, got.unit_tangent_z);
      compare_field("unit_tangent_w", want.unit_tangent_w, got.unit_tangent_w);
      compare_field("normal_is_zero", 16'(want.normal_is_zero), 16'(got.normal_is_zero));
      compare_field("tangent_degenerate", 16'(want.tangent_degenerate),
                    16'(got.tangent_degenerate));
   endfunction
endclass

module vector4_orthonormalize_top_tb;

   localparam int RANDOM_COUNT = 1000;
   localparam int CALM_COUNT   = 150;    // final requests sent with no idling
   localparam int DRAIN_CYCLES = 80;     // longer than the pipeline latency
   localparam int HOLD_CYCLES  = 300;    // long receiver stall to fill the pipeline
   localparam int CYCLE_LIMIT  = 200000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   frame_scoreboard frames;
   bit              directed_done;
   bit              calm;
   int              cycle_count;

   vector4_orthonormalize_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Results are sampled at the edge where the handshake completes, so the
   // values seen are the ones the block presented before that edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) frames.check_result(rsp_data);
   end

   function automatic req_type make_pair(int n0, int n1, int n2, int n3,
                                         int t0, int t1, int t2, int t3);
      req_type r;
      r.normal_x  = 16'(n0); r.normal_y  = 16'(n1);
      r.normal_z  = 16'(n2); r.normal_w  = 16'(n3);
      r.tangent_x = 16'(t0); r.tangent_y = 16'(t1);
      r.tangent_z = 16'(t2); r.tangent_w = 16'(t3);
      return r;
   endfunction

   function automatic int small_value(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   // Random request. Half are arbitrary full-range pairs; the rest aim at
   // the corners: tiny vectors, a zero normal, a tangent parallel to the
   // normal, a zero tangent and a single nonzero component.
   function automatic req_type random_pair();
      req_type r;
      int      k, lane;
      r = req_type'({$urandom, $urandom, $urandom, $urandom});
      case ($urandom_range(0, 9))
         5: r = make_pair(small_value(8), small_value(8), small_value(8), small_value(8),
                          small_value(8), small_value(8), small_value(8), small_value(8));
         6: begin
            r.normal_x = 0; r.normal_y = 0; r.normal_z = 0; r.normal_w = 0;
         end
         7: begin
            k = small_value(30);
            r = make_pair(small_value(1000), small_value(1000), small_value(1000),
                          small_value(1000), 0, 0, 0, 0);
            r.tangent_x = 16'(k * r.normal_x); r.tangent_y = 16'(k * r.normal_y);
            r.tangent_z = 16'(k * r.normal_z); r.tangent_w = 16'(k * r.normal_w);
         end
         8: begin
            r.tangent_x = 0; r.tangent_y = 0; r.tangent_z = 0; r.tangent_w = 0;
         end
         9: begin
            lane = $urandom_range(0, 3);
            if (lane != 0) r.normal_x = 0;
            if (lane != 1) r.normal_y = 0;
            if (lane != 2) r.normal_z = 0;
            if (lane != 3) r.normal_w = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offers one request and holds it until the block takes it. A random
   // burst of idle cycles may come first unless the run is in its calm tail.
   task automatic send_request(req_type r);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      frames.note_request(r);
   endtask

   // Receiver side: random stall bursts, one long hold-off right after the
   // directed requests, and a steady ready during the calm tail.
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_ready <= 1'b1;
      wait (directed_done);
      @(posedge clock);
      rsp_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            // A stretch with no stalls at all.
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   initial begin
      req_type directed[$];
      int      waited;
      frames        = new();
      directed_done = 0;
      calm          = 0;
      cycle_count   = 0;
      req_valid     = 1'b0;
      req_data      = '0;
      reset         = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero normal, with and without a tangent.
      directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_pair(0, 0, 0, 0, 5, -7, 32767, -32768));
      // Single nonzero component saturates to full scale with its sign.
      directed.push_back(make_pair(1, 0, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_pair(0, -32768, 0, 0, 0, 0, 0, 32767));
      directed.push_back(make_pair(0, 0, 32767, 0, -32768, 0, 0, 0));
      directed.push_back(make_pair(0, 0, 0, -1, 0, 0, 3, 0));
      // Zero tangent and tangents parallel to the normal leave no residual.
      directed.push_back(make_pair(3, 4, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_pair(3, 4, 5, 6, -6, -8, -10, -12));
      directed.push_back(make_pair(-32768, -32768, -32768, -32768, 1, 1, 1, 1));
      directed.push_back(make_pair(1, 2, 3, 4, 1, 2, 3, 4));
      // Field extremes.
      directed.push_back(make_pair(32767, 32767, 32767, 32767,
                                   -32768, -32768, -32768, -32768));
      directed.push_back(make_pair(-32768, 32767, -32768, 32767,
                                   32767, 32767, -32768, -32768));
      directed.push_back(make_pair(-32768, 0, 0, 0, -32768, 32767, 0, 0));
      directed.push_back(make_pair(1, 1, 1, 1, 1, -1, 1, -1));
      directed.push_back(make_pair(-1, -1, -1, -1, 32767, 0, 0, 0));
      directed.push_back(make_pair(1, 0, 0, 0, 32767, 32767, 32767, 32767));
      directed.push_back(make_pair(32767, 1, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_pair(16384, -16384, 0, 0, 1, 1, 0, 0));

      foreach (directed[i]) send_request(directed[i]);
      directed_done = 1;

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i >= RANDOM_COUNT - CALM_COUNT) calm = 1;
         send_request(random_pair());
      end
      req_valid <= 1'b0;

      waited = 0;
      while (frames.owed_q.size() != 0 && waited < CYCLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (frames.errors == 0 && frames.owed_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         if (frames.owed_q.size() != 0)
            $display("%0t: %0d results never arrived", $time, frames.owed_q.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
